@@ rtl/mset_pkg.sv @@
// Shared types, constants and the log2 mantissa table for the Mandelbrot
// smooth escape-time block. No dependencies.
package mset_pkg;

  localparam int COORD_FRAC_BITS = 28;
  localparam int LOG_TABLE_BITS  = 8;
  localparam int WORK_FRAC       = 28;
  localparam int DOWN_SHIFT = (COORD_FRAC_BITS > WORK_FRAC) ? COORD_FRAC_BITS - WORK_FRAC : 0;
  localparam int UP_SHIFT   = (COORD_FRAC_BITS < WORK_FRAC) ? WORK_FRAC - COORD_FRAC_BITS : 0;
  localparam int TABLE_SIZE = (1 << LOG_TABLE_BITS) + 1;
  localparam int FRAC_LSBS  = 31 - LOG_TABLE_BITS;

  typedef logic [16:0] rom_t [TABLE_SIZE];

  // log2(1 + i/2^N) in Q.16 by repeated squaring in Q1.30
  function automatic rom_t build_rom();
    rom_t t;
    logic [63:0] y;
    logic [16:0] v;
    for (int i = 0; i < (1 << LOG_TABLE_BITS); i++) begin
      y = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      v = '0;
      for (int k = 0; k < 17; k++) begin
        y = (y * y) >> 30;
        v = {v[15:0], 1'b0};
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          v[0] = 1'b1;
        end
      end
      t[i] = 17'((18'(v) + 18'd1) >> 1);
    end
    t[1 << LOG_TABLE_BITS] = 17'd65536;
    return t;
  endfunction

  localparam rom_t LOG_ROM = build_rom();

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_stat_t;

endpackage

@@ rtl/mset_mult.sv @@
// Shared 33x33 unsigned multiplier with registered product.
// Depends on nothing.
module mset_mult (
  input  logic        clk,
  input  logic        en,
  input  logic [32:0] a,
  input  logic [32:0] b,
  output logic [65:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 66'(a) * 66'(b);
    end
  end

endmodule

@@ rtl/mset_div.sv @@
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// Depends on mset_pkg; caller guarantees dividend / divisor < 2^16.
module mset_div (
  input  logic                clk,
  input  logic                rst,
  input  mset_pkg::div_ctrl_t ctrl,
  output mset_pkg::div_stat_t stat
);

  logic [15:0] rem;
  logic [15:0] dsh;
  logic [15:0] dvs;
  logic [15:0] quo;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [16:0] trial;
  logic        fit;

  assign trial = {rem, dsh[15]};
  assign fit   = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= ctrl.dividend[31:16];
      dsh <= ctrl.dividend[15:0];
      dvs <= ctrl.divisor;
    end else if (busy) begin
      rem <= fit ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      dsh <= {dsh[14:0], 1'b0};
      quo <= {quo[14:0], fit};
    end
  end

  assign stat.done     = done;
  assign stat.quotient = quo;

endmodule

@@ rtl/mandelbrot_smooth_escape_time_top.sv @@
// Mandelbrot smooth escape-time top: sequencer, iteration registers, log unit,
// output register. Depends on mset_pkg, mset_mult and mset_div.
//
// channel | handshake            | payload
// in      | in_valid / in_stall  | c_real, c_imag
// out     | out_valid / out_stall| shade, iterations_done, escaped
// cfg     | cfg_wr_en            | cfg_wr_data (iteration_limit)
//
// Each item is accepted in IDLE, iterates on the shared multiplier through MXY, MXX and
// MYY up to a final compare in MXY, takes at most two log passes (one normalize shift
// per cycle in NORM, then a sum in LSUM), a shade step, the divider when needed and
// the output register. in_stall is high while an item is in work. The finished item
// waits in DONE only while the output register is full and stalled. Reset is
// synchronous; limit resets to 256.
module mandelbrot_smooth_escape_time_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] c_real,
  input  logic [31:0] c_imag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] shade,
  output logic [15:0] iterations_done,
  output logic        escaped,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  typedef enum logic [8:0] {
    IDLE  = 9'b000000001,
    MXY   = 9'b000000010,
    MXX   = 9'b000000100,
    MYY   = 9'b000001000,
    NORM  = 9'b000010000,
    LSUM  = 9'b000100000,
    SHADE = 9'b001000000,
    DIVW  = 9'b010000000,
    DONE  = 9'b100000000
  } state_t;

  localparam logic [36:0] FOUR_W = 37'd4 << mset_pkg::WORK_FRAC;
  localparam logic [36:0] ONE_W  = 37'd1 << mset_pkg::WORK_FRAC;
  localparam int LTB = mset_pkg::LOG_TABLE_BITS;
  localparam int FRAC_W = mset_pkg::FRAC_LSBS;

  function automatic logic signed [31:0] to_work(input logic [31:0] v);
    logic [32:0] sx;
    logic [32:0] mg;
    logic [44:0] sh;
    logic [44:0] mm;
    logic [44:0] lim;
    sx  = {v[31], v};
    mg  = v[31] ? 33'(33'd0 - sx) : sx;
    sh  = 45'(mg >> mset_pkg::DOWN_SHIFT) << mset_pkg::UP_SHIFT;
    lim = 45'd1 << 31;
    if (v[31]) begin
      mm = (sh > lim) ? lim : sh;
      return 32'(45'd0 - mm);
    end
    mm = (sh > lim - 45'd1) ? lim - 45'd1 : sh;
    return 32'(mm);
  endfunction

  function automatic logic [32:0] mag34(input logic signed [33:0] x);
    return x[33] ? 33'(34'd0 - x) : x[32:0];
  endfunction

  state_t state;
  logic [15:0] limit;
  logic signed [31:0] cx, cy;
  logic signed [33:0] zx, zy;
  logic [36:0] zx2;
  logic [15:0] iter;
  logic neg_xy;
  logic [36:0] nx;
  logic [5:0]  e;
  logic        pass;
  logic [16:0] lo_q;
  logic        sat;
  logic signed [34:0] s;
  logic [15:0] shade_q;
  logic        esc_q;

  logic        mul_en;
  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;

  mset_pkg::div_ctrl_t div_ctrl;
  mset_pkg::div_stat_t div_stat;

  mset_mult u_mult (.clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .prod(prod));
  mset_div  u_div  (.clk(clk), .rst(rst), .ctrl(div_ctrl), .stat(div_stat));

  logic [36:0] zy2c, msum;
  logic        go_on;
  logic signed [39:0] zx_new, pxy, dbl, zy_new;
  logic        norm_done;
  logic [LTB-1:0] idx;
  logic [16:0] lo, hi;
  logic [FRAC_W-1:0] rr;
  logic signed [25:0] ediff, lval;
  logic [16:0] frac;

  assign zy2c  = prod[64:28];
  assign msum  = zx2 + zy2c;
  assign go_on = (msum < FOUR_W) && (iter < limit);
  assign zx_new = $signed({3'b0, zx2}) - $signed({3'b0, zy2c}) + 40'(cx);
  assign pxy   = $signed({4'b0, prod[63:28]});
  assign dbl   = neg_xy ? -(pxy <<< 1) : (pxy <<< 1);
  assign zy_new = dbl + 40'(cy);

  assign norm_done = nx[36] || (e == 6'd0);
  assign idx  = nx[35 -: LTB];
  assign rr   = nx[35-LTB -: FRAC_W];
  assign lo   = mset_pkg::LOG_ROM[idx];
  assign hi   = mset_pkg::LOG_ROM[(LTB+1)'(idx) + (LTB+1)'(1)];
  assign frac = prod[FRAC_W +: 17];
  assign ediff = $signed({20'b0, e}) - (pass ? 26'sd17 : 26'sd28);
  assign lval  = (ediff <<< 16) + $signed({9'b0, lo_q}) + $signed({9'b0, frac});

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      MXY: begin
        mul_a = mag34(zx);
        mul_b = mag34(zy);
      end
      MXX: begin
        mul_a = mag34(zx);
        mul_b = mag34(zx);
      end
      MYY: begin
        mul_a = mag34(zy);
        mul_b = mag34(zy);
      end
      NORM: begin
        mul_a = 33'(hi - lo);
        mul_b = 33'(rr);
      end
      IDLE: mul_en = 1'b1;
      default: mul_en = 1'b0;
    endcase
  end

  assign in_stall = (state != IDLE);

  always_comb begin
    div_ctrl.start    = (state == SHADE) && !(limit == 16'd0 || sat || s[34] || s == 35'sd0
                        || s[33:16] >= {2'b0, limit});
    div_ctrl.dividend = s[31:0];
    div_ctrl.divisor  = limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= 16'd256;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= MXY;
          end
        end
        MXY: begin
          if (go_on) begin
            state <= MXX;
          end else if (msum > ONE_W) begin
            state <= NORM;
          end else begin
            state <= SHADE;
          end
        end
        MXX: state <= MYY;
        MYY: state <= MXY;
        NORM: begin
          if (norm_done) begin
            state <= LSUM;
          end
        end
        LSUM: begin
          if (pass || lval <= 26'sd0) begin
            state <= SHADE;
          end else begin
            state <= NORM;
          end
        end
        SHADE: state <= div_ctrl.start ? DIVW : DONE;
        DIVW: begin
          if (div_stat.done) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!out_valid || !out_stall) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      IDLE: begin
        cx   <= to_work(c_real);
        cy   <= to_work(c_imag);
        zx   <= '0;
        zy   <= '0;
        zx2  <= '0;
        iter <= '0;
        sat  <= 1'b0;
        pass <= 1'b0;
      end
      MXY: begin
        if (go_on) begin
          zx     <= 34'(zx_new);
          neg_xy <= zx[33] ^ zy[33];
          iter   <= iter + 16'd1;
        end else begin
          esc_q <= msum >= FOUR_W;
          nx    <= msum;
          e     <= 6'd36;
          s     <= $signed({3'b0, iter, 16'b0});
        end
      end
      MXX: zy <= 34'(zy_new);
      MYY: zx2 <= prod[64:28];
      NORM: begin
        if (norm_done) begin
          lo_q <= lo;
        end else begin
          nx <= {nx[35:0], 1'b0};
          e  <= e - 6'd1;
        end
      end
      LSUM: begin
        if (pass) begin
          s <= $signed({3'b0, iter, 16'b0}) - 35'(lval);
        end else if (lval <= 26'sd0) begin
          sat <= 1'b1;
        end else begin
          nx   <= {11'b0, lval};
          e    <= 6'd36;
          pass <= 1'b1;
        end
      end
      SHADE: begin
        if (limit == 16'd0 || (!sat && (s[34] || s == 35'sd0))) begin
          shade_q <= 16'd0;
        end else begin
          shade_q <= 16'hFFFF;
        end
      end
      DIVW: begin
        if (div_stat.done) begin
          shade_q <= div_stat.quotient;
        end
      end
      DONE: begin
        if (!out_valid || !out_stall) begin
          shade           <= shade_q;
          iterations_done <= iter;
          escaped         <= esc_q;
        end
      end
      default: ;
    endcase
  end

endmodule
